>>> rtl/rau_pkg.sv
// rau_pkg: shared constants, opcode codes and controller/datapath bundles
// for the rational arithmetic unit; no dependencies
package rau_pkg;

  localparam int WIDTH  = 16;
  localparam int MW     = WIDTH + 1;
  localparam int PW     = 2 * WIDTH;
  localparam int RW     = 33;
  localparam int DIV_CW = $clog2(MW + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;

  localparam logic [2:0] PAIR_AN_BD = 3'd0;
  localparam logic [2:0] PAIR_BN_AD = 3'd1;
  localparam logic [2:0] PAIR_AN_BN = 3'd2;
  localparam logic [2:0] PAIR_AD_BD = 3'd3;
  localparam logic [2:0] PAIR_AD_BN = 3'd4;

  localparam logic [1:0] DSEL_MN  = 2'd0;
  localparam logic [1:0] DSEL_ANG = 2'd1;
  localparam logic [1:0] DSEL_ADG = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic [2:0] pair;
    logic       num_load;
    logic       num_add;
    logic       num_sub;
    logic       den_load;
    logic       res_clr;
    logic       pass_a;
    logic       div_start;
    logic [1:0] div_sel;
    logic       gcd_step;
    logic       num_quot;
    logic       den_quot;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic m_zero;
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

>>> rtl/rau_div.sv
// rau_div: signed truncating divider, restoring, one quotient bit per cycle
// depends on rau_pkg
module rau_div import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [MW-1:0] dividend,
  input  logic signed [MW-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic signed [MW:0]   quot,
  output logic signed [MW-1:0] rem
);

  logic [MW-1:0]     mag_b;
  logic [MW-1:0]     qa;
  logic [MW-1:0]     ra;
  logic              neg_q;
  logic              neg_r;
  logic [DIV_CW-1:0] cnt;
  logic [MW-1:0]     abs_a;
  logic [MW-1:0]     abs_b;
  logic [MW:0]       shifted;
  logic [MW:0]       diff;
  logic              ge;

  assign abs_a   = dividend[MW-1] ? MW'(-dividend) : MW'(dividend);
  assign abs_b   = divisor[MW-1] ? MW'(-divisor) : MW'(divisor);
  assign shifted = {ra, qa[MW-1]};
  assign ge      = shifted >= {1'b0, mag_b};
  assign diff    = shifted - {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(MW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_b <= abs_b;
      qa    <= abs_a;
      ra    <= '0;
      neg_q <= dividend[MW-1] ^ divisor[MW-1];
      neg_r <= dividend[MW-1];
    end else if (busy) begin
      ra <= ge ? diff[MW-1:0] : shifted[MW-1:0];
      qa <= {qa[MW-2:0], ge};
    end
  end

  assign quot = neg_q ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
  assign rem  = neg_r ? -$signed(ra) : $signed(ra);

endmodule

>>> rtl/rau_dpath.sv
// rau_dpath: operand registers, shared multiplier, gcd registers and result
// registers; depends on rau_pkg and rau_div
module rau_dpath import rau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic signed [WIDTH-1:0] a_num,
  input  logic signed [WIDTH-1:0] a_den,
  input  logic signed [WIDTH-1:0] b_num,
  input  logic signed [WIDTH-1:0] b_den,
  output logic signed [RW-1:0]    res_num,
  output logic signed [RW-1:0]    res_den,
  output logic                    zero_den
);

  logic signed [WIDTH-1:0] an;
  logic signed [WIDTH-1:0] ad;
  logic signed [WIDTH-1:0] bn;
  logic signed [WIDTH-1:0] bd;
  logic signed [MW-1:0]    m;
  logic signed [MW-1:0]    n;
  logic signed [PW-1:0]    prod;
  logic signed [RW-1:0]    num;
  logic signed [RW-1:0]    den;
  logic signed [WIDTH-1:0] mul_x;
  logic signed [WIDTH-1:0] mul_y;
  logic signed [MW-1:0]    div_a;
  logic signed [MW-1:0]    div_b;
  logic signed [MW:0]      quot;
  logic signed [MW-1:0]    rem;
  logic                    div_busy;
  logic                    div_done;

  always_comb begin
    case (cmd.pair)
      PAIR_AN_BD: begin mul_x = an; mul_y = bd; end
      PAIR_BN_AD: begin mul_x = bn; mul_y = ad; end
      PAIR_AN_BN: begin mul_x = an; mul_y = bn; end
      PAIR_AD_BD: begin mul_x = ad; mul_y = bd; end
      PAIR_AD_BN: begin mul_x = ad; mul_y = bn; end
      default:    begin mul_x = '0; mul_y = '0; end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_MN:  begin div_a = m;          div_b = n; end
      DSEL_ANG: begin div_a = MW'(an);    div_b = m; end
      DSEL_ADG: begin div_a = MW'(ad);    div_b = m; end
      default:  begin div_a = m;          div_b = n; end
    endcase
  end

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
    if (cmd.load_in) begin
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
      m  <= MW'(a_num);
      n  <= MW'(a_den);
    end else if (cmd.gcd_step) begin
      m <= n;
      n <= rem;
    end
    if (cmd.num_load) num <= RW'(prod);
    if (cmd.num_add)  num <= num + RW'(prod);
    if (cmd.num_sub)  num <= num - RW'(prod);
    if (cmd.den_load) den <= RW'(prod);
    if (cmd.num_quot) num <= RW'(quot);
    if (cmd.den_quot) den <= RW'(quot);
    if (cmd.pass_a) begin
      num <= RW'(an);
      den <= RW'(ad);
    end
    if (cmd.res_clr) begin
      num <= '0;
      den <= '0;
    end
    if (cmd.out_load) begin
      res_num  <= num;
      res_den  <= den;
      zero_den <= (den == '0);
    end
  end

  assign status.n_zero   = (n == '0);
  assign status.m_zero   = (m == '0);
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;

endmodule

>>> rtl/rau_ctrl.sv
// rau_ctrl: sequencer for multiply-accumulate and euclid reduction steps,
// output word handshake; depends on rau_pkg
module rau_ctrl import rau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic [2:0] opcode,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_M1     = 4'd1;
  localparam logic [3:0] S_M2     = 4'd2;
  localparam logic [3:0] S_M3     = 4'd3;
  localparam logic [3:0] S_M4     = 4'd4;
  localparam logic [3:0] S_G_TEST = 4'd5;
  localparam logic [3:0] S_G_WAIT = 4'd6;
  localparam logic [3:0] S_G_END  = 4'd7;
  localparam logic [3:0] S_Q1     = 4'd8;
  localparam logic [3:0] S_Q2     = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] op;
  logic       addsub;

  assign in_ready = (state == S_IDLE);
  assign addsub   = (op == OP_ADD) || (op == OP_SUB);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (opcode == OP_RED) begin
            state_next = S_G_TEST;
          end else if (opcode <= OP_DIV) begin
            state_next = S_M1;
          end else begin
            cmd.res_clr = 1'b1;
            state_next  = S_FIN;
          end
        end
      end
      S_M1: begin
        cmd.pair   = (op == OP_MUL) ? PAIR_AN_BN : PAIR_AN_BD;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.num_load = 1'b1;
        if (addsub) begin
          cmd.pair = PAIR_BN_AD;
        end else if (op == OP_MUL) begin
          cmd.pair = PAIR_AD_BD;
        end else begin
          cmd.pair = PAIR_AD_BN;
        end
        state_next = S_M3;
      end
      S_M3: begin
        if (addsub) begin
          cmd.pair    = PAIR_AD_BD;
          cmd.num_add = (op == OP_ADD);
          cmd.num_sub = (op == OP_SUB);
          state_next  = S_M4;
        end else begin
          cmd.den_load = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_M4: begin
        cmd.den_load = 1'b1;
        state_next   = S_FIN;
      end
      S_G_TEST: begin
        if (status.n_zero) begin
          state_next = S_G_END;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_MN;
          state_next    = S_G_WAIT;
        end
      end
      S_G_WAIT: begin
        if (status.div_done) begin
          cmd.gcd_step = 1'b1;
          state_next   = S_G_TEST;
        end
      end
      S_G_END: begin
        if (status.m_zero) begin
          cmd.pass_a = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_ANG;
          state_next    = S_Q1;
        end
      end
      S_Q1: begin
        if (status.div_done) begin
          cmd.num_quot  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_ADG;
          state_next    = S_Q2;
        end
      end
      S_Q2: begin
        if (status.div_done) begin
          cmd.den_quot = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op <= opcode;
    end
  end

  // a pending result word is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten while pending");

  // divider is never restarted mid-division
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // accepting a word leaves idle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while working");

  // each remainder step returns to the zero test
  assert property (@(posedge clk) disable iff (rst)
    (state == S_G_WAIT && status.div_done) |=> (state == S_G_TEST))
    else $error("gcd step lost");

endmodule

>>> rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level joining controller and datapath
// depends on rau_pkg, rau_ctrl, rau_dpath
//
// One word in, one result word out. Add, subtract, multiply and divide go
// through one shared 16x16 multiplier, one product a cycle. Multiply and
// divide step through states M1 to M3 and add and subtract through M1 to M4
// before FIN loads the result, and an unused opcode goes straight to FIN and
// gives 0/0. Reduce runs Euclid's remainder loop on a restoring divider that
// produces one quotient bit a cycle, then, unless the gcd is zero, two more
// divisions by the gcd. The result sits in an output register, so the next
// word is accepted while the previous result still waits to be taken.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              opcode,
  input  logic signed [WIDTH-1:0] a_num,
  input  logic signed [WIDTH-1:0] a_den,
  input  logic signed [WIDTH-1:0] b_num,
  input  logic signed [WIDTH-1:0] b_den,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RW-1:0]    res_num,
  output logic signed [RW-1:0]    res_den,
  output logic                    zero_den
);

  cmd_t    cmd;
  status_t status;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rau_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .res_num  (res_num),
    .res_den  (res_den),
    .zero_den (zero_den)
  );

endmodule
